// ===== rtl/afr_pkg.sv =====
// shared types, constants and reply byte tables for the amqp frame responder
package afr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned IDX_W = 5;

  localparam logic [7:0] END_MARK = 8'hCE;
  localparam logic [7:0] KIND_HEARTBEAT = 8'd8;
  localparam logic [7:0] KIND_METHOD = 8'd1;

  localparam logic [1:0] ST_REPLY = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_BAD_END = 2'd2;

  localparam logic [IDX_W-1:0] START_LEN = 5'd30;
  localparam logic [IDX_W-1:0] HB_LEN = 5'd8;
  localparam logic [IDX_W-1:0] METHOD_LEN = 5'd12;
  localparam logic [IDX_W-1:0] STATUS_LEN = 5'd1;

  localparam logic [7:0] START_FRAME [30] = '{
    8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd22,
    8'd0, 8'd10, 8'd0, 8'd10, 8'd0, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd5, 8'h50, 8'h4C, 8'h41, 8'h49, 8'h4E,
    8'd5, 8'h65, 8'h6E, 8'h5F, 8'h55, 8'h53,
    8'hCE
  };

  typedef enum logic [2:0] {
    PH_PROTO,
    PH_CLOSED,
    PH_HEADER,
    PH_PAYLOAD,
    PH_END
  } phase_e;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_CLOSED,
    CMD_BAD_END,
    CMD_HEARTBEAT,
    CMD_METHOD
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [15:0]      channel;
    logic [3:0][7:0]  lead;
  } afr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } afr_qstat_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    magic_byte = 8'h41;
      2'd1:    magic_byte = 8'h4D;
      2'd2:    magic_byte = 8'h51;
      default: magic_byte = 8'h50;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] cmd_len(input cmd_e kind);
    case (kind)
      CMD_START:     cmd_len = START_LEN;
      CMD_HEARTBEAT: cmd_len = HB_LEN;
      CMD_METHOD:    cmd_len = METHOD_LEN;
      default:       cmd_len = STATUS_LEN;
    endcase
  endfunction

  function automatic logic [1:0] cmd_status(input cmd_e kind);
    case (kind)
      CMD_CLOSED:  cmd_status = ST_CLOSED;
      CMD_BAD_END: cmd_status = ST_BAD_END;
      default:     cmd_status = ST_REPLY;
    endcase
  endfunction

  function automatic logic [7:0] cmd_byte(input afr_cmd_t cmd, input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    case (cmd.kind)
      CMD_START: begin
        if (idx < START_LEN) b = START_FRAME[idx];
      end
      CMD_HEARTBEAT: begin
        if (idx == 5'd0) b = KIND_HEARTBEAT;
        else if (idx == 5'd7) b = END_MARK;
      end
      CMD_METHOD: begin
        case (idx)
          5'd0:    b = KIND_METHOD;
          5'd1:    b = cmd.channel[15:8];
          5'd2:    b = cmd.channel[7:0];
          5'd6:    b = 8'd4;
          5'd7:    b = cmd.lead[0];
          5'd8:    b = cmd.lead[1];
          5'd9:    b = cmd.lead[2] + 8'd1;
          5'd10:   b = cmd.lead[3] + 8'd1;
          5'd11:   b = END_MARK;
          default: b = 8'd0;
        endcase
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/amqp_frame_responder.sv =====
// amqp frame responder top level: parser front end, command queue, reply back end
// path: a command enters the queue, then its reply bytes pass the output register
// one byte in per cycle; one reply byte per cycle if tready, 1 to 30 per command
// input stalls only while the command queue (QueueDepth entries) is full
// reset: asynchronous active low, clears parser, queue pointers and output valid
// no clearing pass after reset; the block accepts bytes in the first cycle out of reset
module amqp_frame_responder #(
  parameter int unsigned QueueDepth = afr_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [1:0] status
);

  logic                push;
  afr_pkg::afr_cmd_t   push_cmd;
  afr_pkg::afr_cmd_t   head;
  afr_pkg::afr_qstat_t qstat;
  logic                pop;

  afr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (qstat.full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  afr_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  afr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .stat_i       (qstat),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

endmodule

// ===== rtl/afr_front.sv =====
// front end: protocol header check and frame parser, issues reply commands
module afr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output afr_pkg::afr_cmd_t cmd_o
);

  afr_pkg::phase_e phase_q, phase_d;
  logic [2:0]      idx_q, idx_d;
  logic            ok_q, ok_d;
  logic [7:0]      kind_q, kind_d;
  logic [15:0]     chan_q, chan_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     cnt_q, cnt_d;
  logic [3:0][7:0] lead_q, lead_d;
  logic            accept;
  logic            ok_now;

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= afr_pkg::PH_PROTO;
      idx_q   <= 3'd0;
      ok_q    <= 1'b1;
      kind_q  <= 8'd0;
      chan_q  <= 16'd0;
      len_q   <= 32'd0;
      cnt_q   <= 32'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      ok_q    <= ok_d;
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q <= lead_d;
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    ok_d    = ok_q;
    kind_d  = kind_q;
    chan_d  = chan_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    lead_d  = lead_q;
    ok_now  = ok_q;
    push_o  = 1'b0;
    cmd_o.kind    = afr_pkg::CMD_START;
    cmd_o.channel = chan_q;
    cmd_o.lead    = lead_q;
    if (accept) begin
      case (phase_q)
        afr_pkg::PH_PROTO: begin
          if (idx_q < 3'd4 && in_byte_i != afr_pkg::magic_byte(idx_q[1:0])) ok_now = 1'b0;
          ok_d = ok_now;
          if (idx_q < 3'd7) begin
            idx_d = idx_q + 3'd1;
          end else begin
            idx_d  = 3'd0;
            push_o = 1'b1;
            if (!ok_now) begin
              phase_d    = afr_pkg::PH_CLOSED;
              cmd_o.kind = afr_pkg::CMD_CLOSED;
            end else begin
              phase_d    = afr_pkg::PH_HEADER;
              cmd_o.kind = afr_pkg::CMD_START;
            end
          end
        end
        afr_pkg::PH_HEADER: begin
          if (idx_q == 3'd0) kind_d = in_byte_i;
          else if (idx_q <= 3'd2) chan_d = {chan_q[7:0], in_byte_i};
          else len_d = {len_q[23:0], in_byte_i};
          if (idx_q < 3'd6) begin
            idx_d = idx_q + 3'd1;
          end else begin
            idx_d   = 3'd0;
            cnt_d   = 32'd0;
            phase_d = (len_d == 32'd0) ? afr_pkg::PH_END : afr_pkg::PH_PAYLOAD;
          end
        end
        afr_pkg::PH_PAYLOAD: begin
          if (cnt_q < 32'd4) lead_d[cnt_q[1:0]] = in_byte_i;
          cnt_d = cnt_q + 32'd1;
          if (cnt_d >= len_q) phase_d = afr_pkg::PH_END;
        end
        afr_pkg::PH_END: begin
          phase_d = afr_pkg::PH_HEADER;
          idx_d   = 3'd0;
          if (in_byte_i != afr_pkg::END_MARK) begin
            push_o     = 1'b1;
            cmd_o.kind = afr_pkg::CMD_BAD_END;
          end else if (kind_q == afr_pkg::KIND_HEARTBEAT) begin
            push_o     = 1'b1;
            cmd_o.kind = afr_pkg::CMD_HEARTBEAT;
          end else if (len_q >= 32'd4) begin
            push_o     = 1'b1;
            cmd_o.kind = afr_pkg::CMD_METHOD;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  property p_closed_sticks;
    @(posedge clk_i) disable iff (!rst_ni)
      phase_q == afr_pkg::PH_CLOSED |=> phase_q == afr_pkg::PH_CLOSED;
  endproperty
  a_closed_sticks: assert property (p_closed_sticks) else $error("closed phase left");

  property p_push_not_full;
    @(posedge clk_i) disable iff (!rst_ni) push_o |-> !q_full_i;
  endproperty
  a_push_not_full: assert property (p_push_not_full) else $error("push into full queue");

  property p_payload_bounded;
    @(posedge clk_i) disable iff (!rst_ni)
      phase_q == afr_pkg::PH_PAYLOAD |-> cnt_q < len_q;
  endproperty
  a_payload_bounded: assert property (p_payload_bounded) else $error("payload count overrun");

endmodule

// ===== rtl/afr_queue.sv =====
// command queue between parser and reply serializer
module afr_queue #(
  parameter int unsigned QueueDepth = afr_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  afr_pkg::afr_cmd_t  push_cmd_i,
  input  logic               pop_i,
  output afr_pkg::afr_cmd_t  head_o,
  output afr_pkg::afr_qstat_t stat_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  afr_pkg::afr_cmd_t mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      if (do_pop) rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  property p_cnt_bounded;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt;
  endproperty
  a_cnt_bounded: assert property (p_cnt_bounded) else $error("queue count overflow");

  property p_empty_ptrs;
    @(posedge clk_i) disable iff (!rst_ni) stat_o.empty |-> wr_q == rd_q;
  endproperty
  a_empty_ptrs: assert property (p_empty_ptrs) else $error("empty queue pointers differ");

  property p_full_ptrs;
    @(posedge clk_i) disable iff (!rst_ni) stat_o.full |-> wr_q == rd_q;
  endproperty
  a_full_ptrs: assert property (p_full_ptrs) else $error("full queue pointers differ");

endmodule

// ===== rtl/afr_back.sv =====
// back end: expands queued commands into reply bytes through an output register
module afr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afr_pkg::afr_cmd_t   head_i,
  input  afr_pkg::afr_qstat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic [1:0]          out_status_o
);

  logic [afr_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic [7:0]                byte_q, byte_d;
  logic                      last_q, last_d;
  logic [1:0]                status_q, status_d;
  logic                      load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    idx_d    = idx_q;
    valid_d  = valid_q;
    byte_d   = byte_q;
    last_d   = last_q;
    status_d = status_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !stat_i.empty;
      if (!stat_i.empty) begin
        byte_d   = afr_pkg::cmd_byte(head_i, idx_q);
        status_d = afr_pkg::cmd_status(head_i.kind);
        last_d   = (idx_q == afr_pkg::cmd_len(head_i.kind) - afr_pkg::IDX_W'(1));
        if (last_d) begin
          idx_d = '0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + afr_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;
  assign out_status_o = status_q;

  property p_pop_has_head;
    @(posedge clk_i) disable iff (!rst_ni) pop_o |-> !stat_i.empty;
  endproperty
  a_pop_has_head: assert property (p_pop_has_head) else $error("pop from empty queue");

  property p_status_single;
    @(posedge clk_i) disable iff (!rst_ni)
      valid_q && status_q != afr_pkg::ST_REPLY |-> last_q && byte_q == 8'd0;
  endproperty
  a_status_single: assert property (p_status_single) else $error("status result malformed");

  property p_idx_range;
    @(posedge clk_i) disable iff (!rst_ni) idx_q < afr_pkg::START_LEN;
  endproperty
  a_idx_range: assert property (p_idx_range) else $error("reply index out of range");

endmodule
